@@ rtl/core/kts_pkg.sv @@
// kts_pkg: token kinds, limits, token record type and keyword/symbol tables
// for the keyword token scanner. No dependencies.
`default_nettype none

package kts_pkg;

  localparam int unsigned POS_BITS  = 16;
  localparam int unsigned KIND_BITS = 5;
  localparam int unsigned LEN_BITS  = 5;
  localparam int unsigned VAL_BITS  = 31;
  localparam int unsigned NUM_KW    = 9;

  localparam logic [KIND_BITS-1:0] KIND_IDENT    = 5'd0;
  localparam logic [KIND_BITS-1:0] KIND_NUMBER   = 5'd1;
  localparam logic [KIND_BITS-1:0] KIND_KEYWORD0 = 5'd2;
  localparam logic [KIND_BITS-1:0] KIND_SYMBOL0  = 5'd11;
  localparam logic [KIND_BITS-1:0] KIND_END      = 5'd22;
  localparam logic [KIND_BITS-1:0] KIND_UNKNOWN  = 5'd23;
  localparam logic [KIND_BITS-1:0] KIND_TOO_LONG = 5'd24;

  localparam logic [VAL_BITS-1:0] NUM_MAX = 31'h7FFF_FFFF;
  localparam logic [LEN_BITS-1:0] LEN_CAP = 5'd31;

  // scan modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;

  // register indexes on the configuration port
  localparam logic REG_MAX_IDENT  = 1'b0;
  localparam logic REG_MAX_DIGITS = 1'b1;

  localparam logic [LEN_BITS-1:0] MAX_IDENT_RESET  = 5'd30;
  localparam logic [3:0]          MAX_DIGITS_RESET = 4'd10;

  typedef struct packed {
    logic [KIND_BITS-1:0] token_kind;
    logic [VAL_BITS-1:0]  number_value;
    logic                 saturated;
    logic [POS_BITS-1:0]  start_position;
    logic [LEN_BITS-1:0]  token_length;
    logic                 last_of_run;
  } token_t;

  // keyword lengths: else if int main printf return scanf void while
  function automatic logic [2:0] kw_len(input logic [3:0] k);
    logic [2:0] l;
    case (k)
      4'd0:    l = 3'd4;
      4'd1:    l = 3'd2;
      4'd2:    l = 3'd3;
      4'd3:    l = 3'd4;
      4'd4:    l = 3'd6;
      4'd5:    l = 3'd6;
      4'd6:    l = 3'd5;
      4'd7:    l = 3'd4;
      4'd8:    l = 3'd5;
      default: l = 3'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] i);
    logic [7:0] ch;
    ch = 8'd0;
    case (k)
      4'd0: begin
        case (i)
          3'd0: ch = "e"; 3'd1: ch = "l"; 3'd2: ch = "s"; 3'd3: ch = "e";
          default: ch = 8'd0;
        endcase
      end
      4'd1: begin
        case (i)
          3'd0: ch = "i"; 3'd1: ch = "f";
          default: ch = 8'd0;
        endcase
      end
      4'd2: begin
        case (i)
          3'd0: ch = "i"; 3'd1: ch = "n"; 3'd2: ch = "t";
          default: ch = 8'd0;
        endcase
      end
      4'd3: begin
        case (i)
          3'd0: ch = "m"; 3'd1: ch = "a"; 3'd2: ch = "i"; 3'd3: ch = "n";
          default: ch = 8'd0;
        endcase
      end
      4'd4: begin
        case (i)
          3'd0: ch = "p"; 3'd1: ch = "r"; 3'd2: ch = "i"; 3'd3: ch = "n";
          3'd4: ch = "t"; 3'd5: ch = "f";
          default: ch = 8'd0;
        endcase
      end
      4'd5: begin
        case (i)
          3'd0: ch = "r"; 3'd1: ch = "e"; 3'd2: ch = "t"; 3'd3: ch = "u";
          3'd4: ch = "r"; 3'd5: ch = "n";
          default: ch = 8'd0;
        endcase
      end
      4'd6: begin
        case (i)
          3'd0: ch = "s"; 3'd1: ch = "c"; 3'd2: ch = "a"; 3'd3: ch = "n";
          3'd4: ch = "f";
          default: ch = 8'd0;
        endcase
      end
      4'd7: begin
        case (i)
          3'd0: ch = "v"; 3'd1: ch = "o"; 3'd2: ch = "i"; 3'd3: ch = "d";
          default: ch = 8'd0;
        endcase
      end
      4'd8: begin
        case (i)
          3'd0: ch = "w"; 3'd1: ch = "h"; 3'd2: ch = "i"; 3'd3: ch = "l";
          3'd4: ch = "e";
          default: ch = 8'd0;
        endcase
      end
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  // kind of a one-character token
  function automatic logic [KIND_BITS-1:0] char_kind(input logic [7:0] c);
    logic [KIND_BITS-1:0] kd;
    case (c)
      ",":     kd = KIND_SYMBOL0;
      ";":     kd = KIND_SYMBOL0 + 5'd1;
      "+":     kd = KIND_SYMBOL0 + 5'd2;
      "-":     kd = KIND_SYMBOL0 + 5'd3;
      "*":     kd = KIND_SYMBOL0 + 5'd4;
      "/":     kd = KIND_SYMBOL0 + 5'd5;
      "{":     kd = KIND_SYMBOL0 + 5'd6;
      "}":     kd = KIND_SYMBOL0 + 5'd7;
      "(":     kd = KIND_SYMBOL0 + 5'd8;
      ")":     kd = KIND_SYMBOL0 + 5'd9;
      "=":     kd = KIND_SYMBOL0 + 5'd10;
      ".":     kd = KIND_END;
      default: kd = KIND_UNKNOWN;
    endcase
    return kd;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/kts_char_if.sv @@
// kts_char_if: valid/ready channel carrying one source character per transaction.
// Depends on nothing.
`default_nettype none

interface kts_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

`default_nettype wire

@@ rtl/core/kts_token_if.sv @@
// kts_token_if: valid/ready channel carrying one token per transaction.
// Depends on kts_pkg for field widths.
`default_nettype none

interface kts_token_if;
  import kts_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_BITS-1:0] token_kind;
  logic [VAL_BITS-1:0]  number_value;
  logic                 saturated;
  logic [POS_BITS-1:0]  start_position;
  logic [LEN_BITS-1:0]  token_length;
  logic                 last_of_run;

  modport source (output valid, output token_kind, output number_value, output saturated,
                  output start_position, output token_length, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input number_value, input saturated,
                  input start_position, input token_length, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/keyword_token_scanner.sv @@
// keyword_token_scanner: streaming maximal-munch tokenizer with keyword match.
// Depends on kts_pkg, kts_char_if and kts_token_if.
//
// One source character is taken per clock cycle while the result queue has
// room. The scan state (mode, open token length, number accumulator, keyword
// candidate mask, position) is updated in a single pass at the accepting
// edge, and the tokens a character closes or produces (none, one or two) are
// written straight into a four-entry result queue. A character is taken
// whenever the queue has room for two tokens, so while the sink keeps up the
// block sustains one character per cycle; two tokens from one character go
// out in turn, and a stalled sink holds the input off once three tokens wait.
// The longest path is the multiply-by-ten-and-add of the 31-bit accumulator
// with its saturation compare. Limits are set over the APB port: register 0
// (byte address 0) is the identifier length limit, register 1 (byte address 4)
// the digit-run limit; they should only be written with the scanner idle.
`default_nettype none

module keyword_token_scanner (
  input  wire         clk,
  input  wire         rst_n,
  kts_char_if.sink    in_if,
  kts_token_if.source out_if,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kts_pkg::*;

  // configuration registers
  logic [LEN_BITS-1:0] max_ident_r;
  logic [3:0]          max_digits_r;

  // scan state
  logic [1:0]          mode_r,  mode_nxt;
  logic [LEN_BITS-1:0] len_r,   len_nxt;
  logic [VAL_BITS-1:0] acc_r,   acc_nxt;
  logic                ovf_r,   ovf_nxt;
  logic [NUM_KW-1:0]   cand_r,  cand_nxt;
  logic [POS_BITS-1:0] pos_r,   pos_nxt;
  logic [POS_BITS-1:0] start_r, start_nxt;
  logic                tl_r,    tl_nxt;

  // result queue
  token_t      queue_r [4];
  logic [1:0]  wr_ptr_r, rd_ptr_r;
  logic [2:0]  count_r;

  logic        in_fire, out_fire, cfg_wr;
  logic [7:0]  c;
  logic        is_letter, is_digit, is_space;
  logic        cont_ident, cont_number, start_new;
  token_t      close_tok, char_tok, tok0, tok1;
  logic        has_close, has_char;
  logic [1:0]  n_tok;

  // working values for extending a token
  logic [LEN_BITS-1:0] b_len;
  logic [VAL_BITS-1:0] b_acc;
  logic                b_ovf, b_tl;
  logic [NUM_KW-1:0]   b_cand;
  logic [NUM_KW-1:0]   id_cand;
  logic [34:0]         dig_sum;
  logic                dig_ovf;
  logic [LEN_BITS-1:0] grown_len;
  logic [LEN_BITS-1:0] limit;

  assign in_fire  = in_if.valid & in_if.ready;
  assign out_fire = out_if.valid & out_if.ready;
  // no transaction is taken while reset is held
  assign in_if.ready = rst_n && (count_r <= 3'd2);

  // ---------------------------------------------------------------- apb port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[2])
      REG_MAX_IDENT:  prdata = {27'd0, max_ident_r};
      REG_MAX_DIGITS: prdata = {28'd0, max_digits_r};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_ident_r  <= MAX_IDENT_RESET;
      max_digits_r <= MAX_DIGITS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAX_IDENT) begin
        max_ident_r <= pwdata[LEN_BITS-1:0];
      end else begin
        max_digits_r <= pwdata[3:0];
      end
    end
  end

  // ---------------------------------------------------------- classification
  assign c         = in_if.char_code;
  assign is_letter = (c >= "a") && (c <= "z");
  assign is_digit  = (c >= "0") && (c <= "9");
  assign is_space  = (c == " ") || (c == 8'd9) || (c == 8'd10);

  assign cont_ident  = (mode_r == MODE_IDENT) && (is_letter || is_digit);
  assign cont_number = (mode_r == MODE_NUMBER) && is_digit;
  assign start_new   = !cont_ident && !cont_number && (is_letter || is_digit);

  // token that closes the open identifier or number
  always_comb begin
    close_tok                = '0;
    close_tok.start_position = start_r;
    close_tok.token_length   = len_r;
    if (tl_r) begin
      close_tok.token_kind = KIND_TOO_LONG;
    end else if (mode_r == MODE_NUMBER) begin
      close_tok.token_kind   = KIND_NUMBER;
      close_tok.number_value = acc_r;
      close_tok.saturated    = ovf_r;
    end else begin
      close_tok.token_kind = KIND_IDENT;
      for (int k = 0; k < NUM_KW; k++) begin
        if (cand_r[k] && ({2'b00, kw_len(4'(k))} == len_r)) begin
          close_tok.token_kind = KIND_KEYWORD0 + 5'(k);
        end
      end
    end
  end

  // ------------------------------------------------------------ token growth
  // base state: the open token when extending, a fresh token when starting
  always_comb begin
    if (start_new) begin
      b_len  = '0;
      b_acc  = '0;
      b_ovf  = 1'b0;
      b_tl   = 1'b0;
      b_cand = '1;
    end else begin
      b_len  = len_r;
      b_acc  = acc_r;
      b_ovf  = ovf_r;
      b_tl   = tl_r;
      b_cand = cand_r;
    end
  end

  // keyword candidates survive while the character matches at this offset
  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      id_cand[k] = b_cand[k] && ({2'b00, kw_len(4'(k))} > b_len) &&
                   (kw_char(4'(k), b_len[2:0]) == c);
    end
  end

  // acc * 10 + digit, saturating at the largest positive 32-bit value
  assign dig_sum = {1'b0, b_acc, 3'b000} + {3'b000, b_acc, 1'b0} + {31'd0, c[3:0]};
  assign dig_ovf = b_ovf || (dig_sum > {4'd0, NUM_MAX});

  assign limit     = (is_letter || cont_ident) ? max_ident_r : {1'b0, max_digits_r};
  assign grown_len = (b_len == LEN_CAP) ? LEN_CAP : b_len + 5'd1;

  // ------------------------------------------------------------- next state
  always_comb begin
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    cand_nxt  = cand_r;
    start_nxt = start_r;
    tl_nxt    = tl_r;
    pos_nxt   = pos_r + 16'd1;

    has_close = 1'b0;
    has_char  = 1'b0;
    char_tok                = '0;
    char_tok.start_position = pos_r;
    char_tok.token_length   = 5'd1;
    char_tok.token_kind     = char_kind(c);

    if (in_if.end_of_input) begin
      // close whatever is open, then a zero-length end token; position restarts
      has_close      = (mode_r != MODE_IDLE);
      has_char       = 1'b1;
      char_tok.token_kind   = KIND_END;
      char_tok.token_length = '0;
      mode_nxt  = MODE_IDLE;
      len_nxt   = '0;
      acc_nxt   = '0;
      ovf_nxt   = 1'b0;
      cand_nxt  = '1;
      start_nxt = '0;
      tl_nxt    = 1'b0;
      pos_nxt   = '0;
    end else if (cont_ident || cont_number || start_new) begin
      has_close = start_new && (mode_r != MODE_IDLE);
      if (start_new) begin
        start_nxt = pos_r;
        mode_nxt  = is_letter ? MODE_IDENT : MODE_NUMBER;
      end
      len_nxt = grown_len;
      tl_nxt  = b_tl || (b_len >= limit) || (b_len == LEN_CAP);
      if (cont_ident || is_letter) begin
        cand_nxt = id_cand;
        acc_nxt  = b_acc;
        ovf_nxt  = b_ovf;
      end else begin
        cand_nxt = b_cand;
        ovf_nxt  = dig_ovf;
        acc_nxt  = dig_ovf ? NUM_MAX : dig_sum[VAL_BITS-1:0];
      end
    end else begin
      // separator, symbol or stray character ends the open token
      has_close = (mode_r != MODE_IDLE);
      has_char  = !is_space;
      mode_nxt  = MODE_IDLE;
      len_nxt   = '0;
      acc_nxt   = '0;
      ovf_nxt   = 1'b0;
      cand_nxt  = '1;
      start_nxt = '0;
      tl_nxt    = 1'b0;
    end
  end

  // order the tokens and mark the final one of the run
  always_comb begin
    tok0  = has_close ? close_tok : char_tok;
    tok1  = char_tok;
    n_tok = {1'b0, has_close} + {1'b0, has_char};
    tok0.last_of_run = (n_tok == 2'd1);
    tok1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      len_r   <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      cand_r  <= '1;
      pos_r   <= '0;
      start_r <= '0;
      tl_r    <= 1'b0;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      len_r   <= len_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      cand_r  <= cand_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      tl_r    <= tl_nxt;
    end
  end

  // ------------------------------------------------------------ result queue
  logic [1:0] n_push;
  assign n_push = in_fire ? n_tok : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + n_push;
      rd_ptr_r <= rd_ptr_r + {1'b0, out_fire};
      count_r  <= count_r + {1'b0, n_push} - {2'b00, out_fire};
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      queue_r[wr_ptr_r] <= tok0;
    end
    if (n_push == 2'd2) begin
      queue_r[wr_ptr_r + 2'd1] <= tok1;
    end
  end

  assign out_if.valid          = (count_r != 3'd0);
  assign out_if.token_kind     = queue_r[rd_ptr_r].token_kind;
  assign out_if.number_value   = queue_r[rd_ptr_r].number_value;
  assign out_if.saturated      = queue_r[rd_ptr_r].saturated;
  assign out_if.start_position = queue_r[rd_ptr_r].start_position;
  assign out_if.token_length   = queue_r[rd_ptr_r].token_length;
  assign out_if.last_of_run    = queue_r[rd_ptr_r].last_of_run;

endmodule

`default_nettype wire

@@ rtl/core/kts_checker.sv @@
// kts_checker: port-level assertions for keyword_token_scanner, and its bind.
// Depends on kts_pkg.
`default_nettype none

module kts_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [kts_pkg::KIND_BITS-1:0] token_kind,
  input wire [kts_pkg::VAL_BITS-1:0]  number_value,
  input wire                          saturated,
  input wire [kts_pkg::LEN_BITS-1:0]  token_length,
  input wire                          last_of_run
);
  import kts_pkg::*;

  // only number tokens carry a value
  a_value_only_numbers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (token_kind != KIND_NUMBER) |-> (number_value == '0) && !saturated)
    else $error("non-number token carries a value");

  // a saturated number shows the ceiling value
  a_saturated_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |-> (number_value == NUM_MAX))
    else $error("saturated number not at ceiling");

  // the end-of-text token is always the final one of its run
  a_eoi_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (token_kind == KIND_END) && (token_length == '0) |-> last_of_run)
    else $error("end-of-text token not last of run");

  // a stalled token holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
      $stable(number_value) && $stable(token_length) && $stable(last_of_run))
    else $error("stalled token changed");

endmodule

bind keyword_token_scanner kts_checker u_kts_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .token_kind   (out_if.token_kind),
  .number_value (out_if.number_value),
  .saturated    (out_if.saturated),
  .token_length (out_if.token_length),
  .last_of_run  (out_if.last_of_run)
);

`default_nettype wire

@@ bench/keyword_token_scanner_tb.sv @@
// keyword_token_scanner_tb: self-checking bench that streams source text into the scanner
// and checks every token against a tokenizer model kept inside the bench.
// Depends on kts_pkg, kts_char_if, kts_token_if and the keyword_token_scanner RTL.
module keyword_token_scanner_tb;
  import kts_pkg::*;

  // one source character as offered on the input channel
  typedef struct packed {
    logic       eoi;
    logic [7:0] code;
  } src_char_t;

  // one row of the directed table; typed rows carry their tokens written out
  typedef struct {
    src_char_t ch;
    bit        typed;
    int        n;
    token_t    t0;
    token_t    t1;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  kts_char_if  in_ch ();
  kts_token_if tok_ch ();

  keyword_token_scanner u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (tok_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // keyword spellings in kind order, and the single-character symbols
  string kw_word [NUM_KW] = '{"else", "if", "int", "main", "printf",
                              "return", "scanf", "void", "while"};
  string sym_set = ",;+-*/{}()=";
  string punct   = "!#$%&:<>?@[]^_|~";

  // tokenizer model state, mirrors what the scanner holds
  logic [1:0]          scan_state;
  logic [LEN_BITS-1:0] run_len;
  logic [31:0]         digit_acc;
  logic                digit_ovf;
  logic [NUM_KW-1:0]   kw_alive;
  logic [POS_BITS-1:0] char_pos;
  logic [POS_BITS-1:0] run_start;
  logic                run_overlong;
  logic [4:0]          ident_limit;
  logic [3:0]          digit_limit;

  token_t    step_tokens [$];  // tokens caused by the character just taken
  token_t    tokens_due [$];   // tokens still owed by the scanner, oldest first
  token_t    due_head;
  src_char_t text_q [$];

  // directed-row overrides, set by the sender alongside valid
  bit     row_typed = 1'b0;
  int     row_n = 0;
  token_t row_tok0;
  token_t row_tok1;

  int          faults = 0;
  int          chars_taken = 0;
  int          tokens_checked = 0;
  int          limit_writes = 0;
  int          holds_done = 0;
  bit          hold_req = 1'b0;
  bit          pacing_on = 1'b1;
  int          burst_left = 0;
  logic [24:0] kinds_seen = '0;

  // ---------------------------------------------------------------------------
  // tokenizer model
  // ---------------------------------------------------------------------------

  function automatic token_t mk_token(logic [KIND_BITS-1:0] kind, logic [VAL_BITS-1:0] val,
                                      logic sat, logic [POS_BITS-1:0] start,
                                      logic [LEN_BITS-1:0] len, logic last);
    token_t t;
    t.token_kind     = kind;
    t.number_value   = val;
    t.saturated      = sat;
    t.start_position = start;
    t.token_length   = len;
    t.last_of_run    = last;
    return t;
  endfunction

  function automatic void clear_run();
    scan_state   = MODE_IDLE;
    run_len      = '0;
    digit_acc    = '0;
    digit_ovf    = 1'b0;
    kw_alive     = '1;
    run_start    = '0;
    run_overlong = 1'b0;
  endfunction

  // one more character in the open run, flagged once the limit is passed
  function automatic void count_char(logic [4:0] limit);
    if (run_len >= limit || run_len == LEN_CAP) run_overlong = 1'b1;
    if (run_len != LEN_CAP) run_len = run_len + 5'd1;
  endfunction

  // a keyword stays a candidate only while every character so far matches it
  function automatic void take_letter(logic [7:0] c);
    int k;
    for (k = 0; k < NUM_KW; k++) begin
      if (!(int'(run_len) < kw_word[k].len() && kw_word[k][run_len] == c)) kw_alive[k] = 1'b0;
    end
    count_char(ident_limit);
  endfunction

  function automatic void take_digit(logic [3:0] d);
    logic [35:0] v;
    v = 36'(digit_acc) * 36'd10 + 36'(d);
    if (digit_ovf || v > 36'(NUM_MAX)) begin
      digit_ovf = 1'b1;
      v         = 36'(NUM_MAX);
    end
    digit_acc = v[31:0];
    count_char({1'b0, digit_limit});
  endfunction

  // emits the open identifier or number, if any, and returns to idle
  function automatic void close_run();
    logic [KIND_BITS-1:0] kind;
    int k;
    if (scan_state == MODE_IDENT) begin
      kind = KIND_IDENT;
      if (run_overlong) begin
        kind = KIND_TOO_LONG;
      end else begin
        for (k = 0; k < NUM_KW; k++)
          if (kw_alive[k] && kw_word[k].len() == int'(run_len)) kind = KIND_KEYWORD0 + 5'(k);
      end
      step_tokens.push_back(mk_token(kind, '0, 1'b0, run_start, run_len, 1'b0));
    end else if (scan_state == MODE_NUMBER) begin
      if (run_overlong)
        step_tokens.push_back(mk_token(KIND_TOO_LONG, '0, 1'b0, run_start, run_len, 1'b0));
      else
        step_tokens.push_back(mk_token(KIND_NUMBER, digit_acc[VAL_BITS-1:0], digit_ovf,
                                       run_start, run_len, 1'b0));
    end
    clear_run();
  endfunction

  // works out the tokens one accepted character causes, maximal munch
  function automatic void lex_step(logic [7:0] c, logic eoi);
    logic                 letter;
    logic                 digit;
    logic [KIND_BITS-1:0] kind;
    int k;
    step_tokens.delete();
    letter = (c >= "a" && c <= "z");
    digit  = (c >= "0" && c <= "9");
    if (eoi) begin
      // end of text: close, end marker of length zero, positions restart
      close_run();
      step_tokens.push_back(mk_token(KIND_END, '0, 1'b0, char_pos, 5'd0, 1'b0));
      clear_run();
      char_pos = '0;
    end else begin
      if (scan_state == MODE_IDENT && (letter || digit)) begin
        take_letter(c);
      end else if (scan_state == MODE_NUMBER && digit) begin
        take_digit(4'(c - "0"));
      end else begin
        close_run();
        if (letter) begin
          scan_state = MODE_IDENT;
          run_start  = char_pos;
          take_letter(c);
        end else if (digit) begin
          scan_state = MODE_NUMBER;
          run_start  = char_pos;
          take_digit(4'(c - "0"));
        end else if (c != " " && c != "\t" && c != "\n") begin
          // period ends a statement but scanning carries on
          kind = (c == ".") ? KIND_END : KIND_UNKNOWN;
          for (k = 0; k < 11; k++)
            if (sym_set[k] == c) kind = KIND_SYMBOL0 + 5'(k);
          step_tokens.push_back(mk_token(kind, '0, 1'b0, char_pos, 5'd1, 1'b0));
        end
      end
      char_pos = char_pos + 16'd1;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: all sampling on the rising edge, inputs only move on the falling one
  // ---------------------------------------------------------------------------

  function automatic void check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", field, want_v, got_v);
      faults++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_run();
      char_pos    = '0;
      ident_limit = MAX_IDENT_RESET;
      digit_limit = MAX_DIGITS_RESET;
    end else begin
      // limit registers follow the write transactions on the config port
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MAX_DIGITS) digit_limit = pwdata[3:0];
        else ident_limit = pwdata[4:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        lex_step(in_ch.char_code, in_ch.end_of_input);
        chars_taken++;
        if (row_typed) begin
          if (row_n > 0) tokens_due.push_back(row_tok0);
          if (row_n > 1) tokens_due.push_back(row_tok1);
        end else begin
          foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
        end
      end
      if (tok_ch.valid && tok_ch.ready) begin
        if (tokens_due.size() == 0) begin
          $error("token with nothing outstanding: kind %0d at position %0d",
                 tok_ch.token_kind, tok_ch.start_position);
          faults++;
        end else begin
          due_head = tokens_due.pop_front();
          check_field("token_kind", 32'(due_head.token_kind), 32'(tok_ch.token_kind));
          check_field("number_value", 32'(due_head.number_value),
                      32'(tok_ch.number_value));
          check_field("saturated", 32'(due_head.saturated), 32'(tok_ch.saturated));
          check_field("start_position", 32'(due_head.start_position),
                      32'(tok_ch.start_position));
          check_field("token_length", 32'(due_head.token_length),
                      32'(tok_ch.token_length));
          check_field("last_of_run", 32'(due_head.last_of_run), 32'(tok_ch.last_of_run));
          if (due_head.token_kind <= KIND_TOO_LONG) kinds_seen[due_head.token_kind] = 1'b1;
          tokens_checked++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // token sink: changes its stall style now and then, and honours a long hold
  // ---------------------------------------------------------------------------

  initial begin : sink_pacing
    int style;
    int left;
    int tick;
    tok_ch.ready = 1'b0;
    style = 0;
    left  = 0;
    tick  = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long back-pressure, the scanner has to fill up and stall its input
        hold_req = 1'b0;
        tok_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
        holds_done++;
      end
      if (left == 0) begin
        style = $urandom_range(0, 3);
        left  = $urandom_range(20, 80);
      end
      left--;
      tick++;
      case (style)
        0: begin
          tok_ch.ready <= 1'b1;
        end
        1: begin
          tok_ch.ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          tok_ch.ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          tok_ch.ready <= (tick % 5 != 0);
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // source text generation
  // ---------------------------------------------------------------------------

  function automatic void put_char(logic [7:0] c);
    text_q.push_back('{eoi: 1'b0, code: c});
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    if ($urandom_range(0, 3) == 0) return 8'("0" + $urandom_range(0, 9));
    return rand_letter();
  endfunction

  // characters that are neither token material nor separators, mostly
  function automatic logic [7:0] rand_unknown();
    case ($urandom_range(0, 3))
      0: return 8'("A" + $urandom_range(0, 25));
      1: return 8'($urandom_range(0, 31));
      2: return 8'($urandom_range(128, 255));
      default: return punct[$urandom_range(0, punct.len() - 1)];
    endcase
  endfunction

  // mostly well-formed program text with random content, some noise mixed in
  function automatic void gen_text(int count);
    int    goal;
    int    pick;
    int    len;
    int    k;
    int    variant;
    string w;
    goal = text_q.size() + count;
    while (text_q.size() < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        // keyword, sometimes one short or one long to miss the match narrowly
        w       = kw_word[$urandom_range(0, NUM_KW - 1)];
        variant = $urandom_range(0, 3);
        len     = (variant == 0) ? w.len() - 1 : w.len();
        for (k = 0; k < len; k++) put_char(w[k]);
        if (variant == 1) put_char(rand_alnum());
      end else if (pick < 40) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
        put_char(rand_letter());
        for (k = 1; k < len; k++) put_char(rand_alnum());
      end else if (pick < 58) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 11);
        for (k = 0; k < len; k++) put_char(8'("0" + $urandom_range(0, 9)));
      end else if (pick < 75) begin
        put_char(sym_set[$urandom_range(0, 10)]);
      end else if (pick < 80) begin
        put_char(".");
      end else if (pick < 85) begin
        put_char(rand_unknown());
      end else if (pick < 88) begin
        text_q.push_back('{eoi: 1'b1, code: 8'($urandom_range(0, 255))});
      end else begin
        put_char(8'($urandom_range(0, 255)));
      end
      // separators between tokens, or none so that tokens abut
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        case ($urandom_range(0, 2))
          0: put_char(" ");
          1: put_char("\t");
          default: put_char("\n");
        endcase
        if (pick == 5) put_char(" ");
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offers one character and returns on the falling edge after its transaction
  task automatic send_char(input src_char_t ch);
    in_ch.valid        <= 1'b1;
    in_ch.char_code    <= ch.code;
    in_ch.end_of_input <= ch.eoi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // bursts of random length with random gaps, some bursts run straight on
  task automatic pace();
    if (!pacing_on) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  endtask

  task automatic play_text();
    foreach (text_q[i]) begin
      send_char(text_q[i]);
      pace();
    end
    text_q.delete();
    in_ch.valid <= 1'b0;
  endtask

  task automatic run_text(input int count);
    text_q.delete();
    gen_text(count);
    play_text();
  endtask

  // waits for every owed token, then lets the scanner settle
  task automatic drain();
    while (tokens_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // one config transaction, setup then access, and idle after it
  task automatic cfg_access(input logic reg_sel, input logic wr, input logic [31:0] data,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // writes both length limits and reads each one back
  task automatic set_limits(input logic [4:0] ident_max, input logic [3:0] digits_max);
    logic [31:0] rd;
    cfg_access(REG_MAX_IDENT, 1'b1, {27'd0, ident_max}, rd);
    cfg_access(REG_MAX_IDENT, 1'b0, 32'd0, rd);
    check_field("max_ident_length", {27'd0, ident_max}, rd);
    cfg_access(REG_MAX_DIGITS, 1'b1, {28'd0, digits_max}, rd);
    cfg_access(REG_MAX_DIGITS, 1'b0, 32'd0, rd);
    check_field("max_number_digits", {28'd0, digits_max}, rd);
    limit_writes++;
  endtask

  function automatic dir_row_t dir_row(logic [7:0] c, logic eoi, bit typed, int n,
                                      token_t t0, token_t t1);
    dir_row_t r;
    r.ch    = '{eoi: eoi, code: c};
    r.typed = typed;
    r.n     = n;
    r.t0    = t0;
    r.t1    = t1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    dir_row_t rows [$];
    token_t   none;
    int       k;
    in_ch.valid        = 1'b0;
    in_ch.char_code    = 8'd0;
    in_ch.end_of_input = 1'b0;
    none = mk_token('0, '0, 1'b0, '0, '0, 1'b0);
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, limits at their reset values (30 and 10)
    rows.push_back(dir_row(",", 1'b0, 1, 1,
                           mk_token(KIND_SYMBOL0, '0, 1'b0, 16'd0, 5'd1, 1'b1), none));
    rows.push_back(dir_row("=", 1'b0, 1, 1,
                           mk_token(KIND_SYMBOL0 + 5'd10, '0, 1'b0, 16'd1, 5'd1, 1'b1), none));
    rows.push_back(dir_row(8'hFF, 1'b0, 1, 1,
                           mk_token(KIND_UNKNOWN, '0, 1'b0, 16'd2, 5'd1, 1'b1), none));
    rows.push_back(dir_row(8'h00, 1'b0, 1, 1,
                           mk_token(KIND_UNKNOWN, '0, 1'b0, 16'd3, 5'd1, 1'b1), none));
    rows.push_back(dir_row(".", 1'b0, 1, 1,
                           mk_token(KIND_END, '0, 1'b0, 16'd4, 5'd1, 1'b1), none));
    // keyword closed by a symbol: two tokens from one character
    rows.push_back(dir_row("i", 1'b0, 0, 0, none, none));
    rows.push_back(dir_row("f", 1'b0, 0, 0, none, none));
    rows.push_back(dir_row("(", 1'b0, 0, 0, none, none));
    // ten nines: fits the digit limit but saturates the value
    for (k = 0; k < 10; k++) rows.push_back(dir_row("9", 1'b0, 0, 0, none, none));
    rows.push_back(dir_row(8'h00, 1'b1, 1, 2,
                           mk_token(KIND_NUMBER, NUM_MAX, 1'b1, 16'd8, 5'd10, 1'b0),
                           mk_token(KIND_END, '0, 1'b0, 16'd18, 5'd0, 1'b1)));
    // positions restart after end of input
    rows.push_back(dir_row("A", 1'b0, 1, 1,
                           mk_token(KIND_UNKNOWN, '0, 1'b0, 16'd0, 5'd1, 1'b1), none));
    rows.push_back(dir_row("\n", 1'b0, 0, 0, none, none));
    rows.push_back(dir_row("\t", 1'b0, 0, 0, none, none));
    rows.push_back(dir_row("z", 1'b0, 0, 0, none, none));
    // end of input with a code that must be ignored, closing an open identifier
    rows.push_back(dir_row(8'hFF, 1'b1, 0, 0, none, none));

    foreach (rows[i]) begin
      row_typed = rows[i].typed;
      row_n     = rows[i].n;
      row_tok0  = rows[i].t0;
      row_tok1  = rows[i].t1;
      send_char(rows[i].ch);
      pace();
    end
    row_typed = 1'b0;
    in_ch.valid <= 1'b0;
    drain();

    // widest limits
    set_limits(5'd31, 4'd15);
    run_text(150);
    drain();

    // narrowest legal limits, almost every run is too long
    set_limits(5'd1, 4'd1);
    run_text(150);
    drain();

    // limit zero, every identifier and number is too long
    set_limits(5'd0, 4'd0);
    run_text(100);
    drain();

    // random limits, with a long sink hold and a full drain mid-stream
    set_limits(5'($urandom_range(1, 31)), 4'($urandom_range(1, 15)));
    run_text(60);
    hold_req = 1'b1;
    run_text(60);
    drain();
    run_text(40);
    drain();

    // restart positions with an unpaced end of input, then paced text straight after
    set_limits(MAX_IDENT_RESET, MAX_DIGITS_RESET);
    text_q.delete();
    text_q.push_back('{eoi: 1'b1, code: 8'd0});
    pacing_on = 1'b0;
    play_text();
    pacing_on = 1'b1;
    run_text(150);
    drain();

    set_limits(5'($urandom_range(1, 31)), 4'($urandom_range(1, 15)));
    run_text(200);
    drain();
    repeat (16) @(negedge clk);

    $display("covered %0d characters and %0d checked tokens, %0d of 25 token kinds seen",
             chars_taken, tokens_checked, $countones(kinds_seen));
    $display("%0d limit settings, %0d long sink holds", limit_writes, holds_done);
    if (faults == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin : watchdog
    #15000000;
    $display("simulation failed");
    $finish;
  end

endmodule
